[src/stt_pkg.sv]
// shared types, codes and character classes for the sql text tokenizer
`default_nettype none
package stt_pkg;

   localparam int unsigned MaxResults = 3;

   // token kind codes
   localparam logic [2:0] KIND_IDENT  = 3'd0;
   localparam logic [2:0] KIND_STRING = 3'd1;
   localparam logic [2:0] KIND_NUMBER = 3'd2;
   localparam logic [2:0] KIND_SYMBOL = 3'd3;
   localparam logic [2:0] KIND_END    = 3'd4;

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0a;
   localparam logic [7:0] CH_CR     = 8'h0d;
   localparam logic [7:0] CH_DOT    = 8'h2e;
   localparam logic [7:0] CH_UNDER  = 8'h5f;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_LT     = 8'h3c;
   localparam logic [7:0] CH_GT     = 8'h3e;
   localparam logic [7:0] CH_EQ     = 8'h3d;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;

   typedef struct packed {
      logic [2:0] token_kind;
      logic [7:0] char_out;
      logic       char_present;
      logic       token_first;
      logic       token_last;
      logic       run_last;
   } result_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a)) ||
             (c == CH_UNDER);
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
   endfunction

   function automatic logic pair_ok(input logic [7:0] a, input logic [7:0] b);
      return ((a == CH_BANG) && (b == CH_EQ)) || ((a == CH_GT) && (b == CH_EQ)) ||
             ((a == CH_LT) && (b == CH_EQ)) || ((a == CH_LT) && (b == CH_GT)) ||
             ((a == CH_EQ) && (b == CH_EQ));
   endfunction

   function automatic result_type mk_result(input logic [2:0] kind, input logic [7:0] ch,
                                            input logic present, input logic first,
                                            input logic last);
      result_type r;
      r.token_kind   = kind;
      r.char_out     = ch;
      r.char_present = present;
      r.token_first  = first;
      r.token_last   = last;
      r.run_last     = 1'b0;
      return r;
   endfunction

endpackage
`default_nettype wire

[src/stt_core.sv]
// lexer state and per-byte step logic producing up to three results
`default_nettype none
module stt_core
   import stt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step_en,
   input  wire logic [7:0] text_byte,
   input  wire logic       end_of_text,
   output result_type      results [MaxResults],
   output logic [1:0]      res_count
);

   typedef enum logic [2:0] {
      MODE_IDLE, MODE_IDENT, MODE_STRING, MODE_NUMBER, MODE_PAIR
   } mode_type;

   mode_type   mode_ff, mode_in;
   logic       dq_ff, dq_in;
   logic [7:0] held_ff, held_in;
   logic       hv_ff, hv_in;
   logic       begun_ff, begun_in;

   logic       cont;
   logic       run_idle;
   logic [7:0] quote;
   logic [1:0] n_v;

   function automatic logic [2:0] kind_of(input mode_type m);
      case (m)
         MODE_IDENT:  return KIND_IDENT;
         MODE_STRING: return KIND_STRING;
         MODE_NUMBER: return KIND_NUMBER;
         default:     return KIND_SYMBOL;
      endcase
   endfunction

   always_comb begin
      mode_in  = mode_ff;
      dq_in    = dq_ff;
      held_in  = held_ff;
      hv_in    = hv_ff;
      begun_in = begun_ff;
      n_v      = 2'd0;
      run_idle = 1'b0;
      cont     = 1'b0;
      quote    = dq_ff ? CH_DQUOTE : CH_SQUOTE;
      for (int i = 0; i < MaxResults; i++) begin
         results[i] = '0;
      end

      unique case (mode_ff)
         MODE_IDENT, MODE_NUMBER: begin
            cont = (mode_ff == MODE_IDENT) ? (is_alpha(text_byte) || is_digit(text_byte))
                                           : (is_digit(text_byte) || text_byte == CH_DOT);
            results[n_v] = mk_result(kind_of(mode_in), held_in, 1'b1, !begun_in, !cont);
            n_v = n_v + 2'd1;
            begun_in = 1'b1;
            hv_in = 1'b0;
            if (cont) begin
               held_in = text_byte;
               hv_in = 1'b1;
            end else begin
               run_idle = 1'b1;
            end
         end
         MODE_STRING: begin
            if (text_byte == quote) begin
               if (hv_in) begin
                  results[n_v] = mk_result(KIND_STRING, held_in, 1'b1, !begun_in, 1'b1);
                  n_v = n_v + 2'd1;
               end else if (!begun_in) begin
                  // empty string
                  results[n_v] = mk_result(KIND_STRING, 8'd0, 1'b0, 1'b1, 1'b1);
                  n_v = n_v + 2'd1;
               end
               mode_in  = MODE_IDLE;
               hv_in    = 1'b0;
               begun_in = 1'b0;
               held_in  = 8'd0;
            end else begin
               if (hv_in) begin
                  results[n_v] = mk_result(KIND_STRING, held_in, 1'b1, !begun_in, 1'b0);
                  n_v = n_v + 2'd1;
                  begun_in = 1'b1;
               end
               held_in = text_byte;
               hv_in = 1'b1;
            end
         end
         MODE_PAIR: begin
            cont = pair_ok(held_ff, text_byte);
            results[n_v] = mk_result(KIND_SYMBOL, held_in, 1'b1, !begun_in, !cont);
            n_v = n_v + 2'd1;
            begun_in = 1'b1;
            hv_in = 1'b0;
            if (cont) begin
               results[n_v] = mk_result(KIND_SYMBOL, text_byte, 1'b1, 1'b0, 1'b1);
               n_v = n_v + 2'd1;
               mode_in  = MODE_IDLE;
               begun_in = 1'b0;
               held_in  = 8'd0;
            end else begin
               run_idle = 1'b1;
            end
         end
         default: begin
            run_idle = 1'b1;
         end
      endcase

      // byte starts fresh between tokens
      if (run_idle) begin
         mode_in  = MODE_IDLE;
         hv_in    = 1'b0;
         begun_in = 1'b0;
         held_in  = 8'd0;
         if (is_space(text_byte)) begin
            mode_in = MODE_IDLE;
         end else if (text_byte == CH_SQUOTE || text_byte == CH_DQUOTE) begin
            mode_in = MODE_STRING;
            dq_in   = (text_byte == CH_DQUOTE);
         end else if (is_digit(text_byte)) begin
            mode_in = MODE_NUMBER;
            held_in = text_byte;
            hv_in   = 1'b1;
         end else if (is_alpha(text_byte)) begin
            mode_in = MODE_IDENT;
            held_in = text_byte;
            hv_in   = 1'b1;
         end else if (text_byte == CH_BANG || text_byte == CH_LT ||
                      text_byte == CH_GT || text_byte == CH_EQ) begin
            mode_in = MODE_PAIR;
            held_in = text_byte;
            hv_in   = 1'b1;
         end else begin
            results[n_v] = mk_result(KIND_SYMBOL, text_byte, 1'b1, 1'b1, 1'b1);
            n_v = n_v + 2'd1;
         end
      end

      // flush and terminate at end of statement
      if (end_of_text) begin
         if (mode_in == MODE_STRING) begin
            if (hv_in) begin
               results[n_v] = mk_result(KIND_STRING, held_in, 1'b1, !begun_in, 1'b1);
               n_v = n_v + 2'd1;
            end else if (!begun_in) begin
               results[n_v] = mk_result(KIND_STRING, 8'd0, 1'b0, 1'b1, 1'b1);
               n_v = n_v + 2'd1;
            end
         end else if (mode_in != MODE_IDLE && hv_in) begin
            results[n_v] = mk_result(kind_of(mode_in), held_in, 1'b1, !begun_in, 1'b1);
            n_v = n_v + 2'd1;
         end
         results[n_v] = mk_result(KIND_END, 8'd0, 1'b0, 1'b1, 1'b1);
         n_v = n_v + 2'd1;
         mode_in  = MODE_IDLE;
         dq_in    = 1'b0;
         held_in  = 8'd0;
         hv_in    = 1'b0;
         begun_in = 1'b0;
      end

      if (n_v != 2'd0) begin
         results[n_v - 2'd1].run_last = 1'b1;
      end
      res_count = n_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         dq_ff    <= 1'b0;
         held_ff  <= 8'd0;
         hv_ff    <= 1'b0;
         begun_ff <= 1'b0;
      end else if (step_en) begin
         mode_ff  <= mode_in;
         dq_ff    <= dq_in;
         held_ff  <= held_in;
         hv_ff    <= hv_in;
         begun_ff <= begun_in;
      end
   end

   a_end_token_last: assert property (@(posedge clock) disable iff (reset)
      step_en && end_of_text |->
         res_count != 2'd0 && results[res_count - 2'd1].token_kind == KIND_END)
      else $error("end of statement does not finish with end token");

   a_state_cleared: assert property (@(posedge clock) disable iff (reset)
      step_en && end_of_text |=> mode_ff == MODE_IDLE && !hv_ff && !begun_ff && !dq_ff)
      else $error("lexer state not cleared after end of statement");

   a_held_not_idle: assert property (@(posedge clock) disable iff (reset)
      hv_ff |-> mode_ff != MODE_IDLE)
      else $error("held character while idle");

   a_run_last_marked: assert property (@(posedge clock) disable iff (reset)
      step_en && res_count != 2'd0 |-> results[res_count - 2'd1].run_last)
      else $error("last result of a byte lacks run_last");

endmodule
`default_nettype wire

[src/stt_outq.sv]
// result buffer for one byte, drained one per cycle unless stalled
`default_nettype none
module stt_outq
   import stt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       load,
   input  wire result_type load_results [MaxResults],
   input  wire logic [1:0] load_count,
   output logic            can_load,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output result_type      head
);

   result_type ent_ff [MaxResults];
   logic [1:0] cnt_ff;
   logic       pop;

   assign rsp_valid = (cnt_ff != 2'd0);
   assign pop       = rsp_valid && !rsp_stall;
   // refill in the same cycle the final entry leaves
   assign can_load  = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && pop);
   assign head      = ent_ff[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else if (load) begin
         cnt_ff <= load_count;
      end else if (pop) begin
         cnt_ff <= cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < MaxResults; i++) begin
            ent_ff[i] <= load_results[i];
         end
      end else if (pop) begin
         ent_ff[0] <= ent_ff[1];
         ent_ff[1] <= ent_ff[2];
      end
   end

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      pop && !load |=> cnt_ff == $past(cnt_ff) - 2'd1)
      else $error("result count not decremented on pop");

   a_load_safe: assert property (@(posedge clock) disable iff (reset)
      load |-> !rsp_valid || (cnt_ff == 2'd1 && !rsp_stall))
      else $error("results overwritten before delivery");

endmodule
`default_nettype wire

[src/sql_text_tokenizer.sv]
// top level: input register, lexer step and result buffer
// path: a byte waits in the input register until the result buffer can load;
//   its results are then registered there, and the first one is valid from it
// throughput: one byte per cycle while each byte yields at most one result and
//   rsp_stall is low; a byte with k results occupies the single-result output port
// reset: synchronous, active high; clears lexer state, input register and buffer
`default_nettype none
module sql_text_tokenizer
   import stt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_text_byte,
   input  wire logic       req_end_of_text,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [2:0]      rsp_token_kind,
   output logic [7:0]      rsp_char_out,
   output logic            rsp_char_present,
   output logic            rsp_token_first,
   output logic            rsp_token_last,
   output logic            rsp_run_last
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] byte_ff;
   logic       end_ff;
   logic       accept;
   logic       consume;
   logic       can_load;

   result_type step_results [MaxResults];
   logic [1:0] step_count;
   result_type head;

   assign consume   = in_valid_ff && can_load;
   assign req_stall = in_valid_ff && !consume;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_text_byte;
         end_ff  <= req_end_of_text;
      end
   end

   stt_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step_en     (consume),
      .text_byte   (byte_ff),
      .end_of_text (end_ff),
      .results     (step_results),
      .res_count   (step_count)
   );

   stt_outq u_outq (
      .clock        (clock),
      .reset        (reset),
      .load         (consume),
      .load_results (step_results),
      .load_count   (step_count),
      .can_load     (can_load),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .head         (head)
   );

   assign rsp_token_kind   = head.token_kind;
   assign rsp_char_out     = head.char_out;
   assign rsp_char_present = head.char_present;
   assign rsp_token_first  = head.token_first;
   assign rsp_token_last   = head.token_last;
   assign rsp_run_last     = head.run_last;

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !consume |=> in_valid_ff && $stable(byte_ff) && $stable(end_ff))
      else $error("pending input transaction lost");

   a_end_present_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == KIND_END |-> !rsp_char_present && rsp_run_last)
      else $error("malformed end token");

endmodule
`default_nettype wire

[tb/tb_top.sv]
// testbench for sql_text_tokenizer: byte stimulus, token prediction and result checking
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   import stt_pkg::*;

   typedef enum logic [2:0] {
      LEX_IDLE, LEX_IDENT, LEX_STRING, LEX_NUMBER, LEX_PAIR
   } lex_mode_type;

   class lexer_scoreboard;
      lex_mode_type mode;
      logic       dq_open;
      logic [7:0] held;
      logic       held_ok;
      logic       begun;
      result_type expected[$];
      int         errors;

      function new();
         errors = 0;
         dq_open = 1'b0;
         go_idle();
      endfunction

      function logic is_num(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction

      function logic is_letter(logic [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
      endfunction

      function logic is_blank(logic [7:0] c);
         return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
      endfunction

      function logic joins(logic [7:0] a, logic [7:0] b);
         return (b == CH_EQ && (a == CH_BANG || a == CH_GT || a == CH_LT || a == CH_EQ)) ||
                (a == CH_LT && b == CH_GT);
      endfunction

      function logic [2:0] mode_kind();
         case (mode)
            LEX_IDENT:  return KIND_IDENT;
            LEX_STRING: return KIND_STRING;
            LEX_NUMBER: return KIND_NUMBER;
            default:    return KIND_SYMBOL;
         endcase
      endfunction

      function void emit(logic [2:0] kind, logic [7:0] ch, logic present, logic first,
                         logic last);
         result_type r;
         r.token_kind   = kind;
         r.char_out     = ch;
         r.char_present = present;
         r.token_first  = first;
         r.token_last   = last;
         r.run_last     = 1'b0;
         expected.push_back(r);
      endfunction

      function void emit_held(logic last);
         emit(mode_kind(), held, 1'b1, !begun, last);
         begun = 1'b1;
         held_ok = 1'b0;
      endfunction

      function void go_idle();
         mode = LEX_IDLE;
         held_ok = 1'b0;
         begun = 1'b0;
         held = 8'h00;
      endfunction

      function void hold_first(lex_mode_type m, logic [7:0] c);
         mode = m;
         held = c;
         held_ok = 1'b1;
         begun = 1'b0;
      endfunction

      function void from_idle(logic [7:0] c);
         if (is_blank(c))
            return;
         if (c == CH_SQUOTE || c == CH_DQUOTE) begin
            mode = LEX_STRING;
            dq_open = (c == CH_DQUOTE);
            held_ok = 1'b0;
            begun = 1'b0;
         end else if (is_num(c))
            hold_first(LEX_NUMBER, c);
         else if (is_letter(c))
            hold_first(LEX_IDENT, c);
         else if (c == CH_BANG || c == CH_LT || c == CH_GT || c == CH_EQ)
            hold_first(LEX_PAIR, c);
         else
            emit(KIND_SYMBOL, c, 1'b1, 1'b1, 1'b1);
      endfunction

      // accepted input transaction: queue every result the byte causes
      function void take_byte(logic [7:0] c, logic eot);
         int         base;
         logic [7:0] close_q;
         logic       more;
         base = expected.size();
         case (mode)
            LEX_IDENT, LEX_NUMBER: begin
               more = (mode == LEX_IDENT) ? (is_letter(c) || is_num(c))
                                          : (is_num(c) || c == CH_DOT);
               if (more) begin
                  emit_held(1'b0);
                  held = c;
                  held_ok = 1'b1;
               end else begin
                  emit_held(1'b1);
                  go_idle();
                  from_idle(c);
               end
            end
            LEX_STRING: begin
               close_q = dq_open ? CH_DQUOTE : CH_SQUOTE;
               if (c == close_q) begin
                  if (held_ok)
                     emit_held(1'b1);
                  else if (!begun)
                     emit(KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b1);
                  go_idle();
               end else begin
                  if (held_ok)
                     emit_held(1'b0);
                  held = c;
                  held_ok = 1'b1;
               end
            end
            LEX_PAIR: begin
               if (joins(held, c)) begin
                  emit_held(1'b0);
                  emit(KIND_SYMBOL, c, 1'b1, 1'b0, 1'b1);
                  go_idle();
               end else begin
                  emit_held(1'b1);
                  go_idle();
                  from_idle(c);
               end
            end
            default: begin
               go_idle();
               from_idle(c);
            end
         endcase
         if (eot) begin
            if (mode == LEX_STRING) begin
               if (held_ok)
                  emit_held(1'b1);
               else if (!begun)
                  emit(KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b1);
            end else if (mode != LEX_IDLE && held_ok)
               emit_held(1'b1);
            emit(KIND_END, 8'h00, 1'b0, 1'b1, 1'b1);
            go_idle();
            dq_open = 1'b0;
         end
         if (expected.size() > base)
            expected[expected.size() - 1].run_last = 1'b1;
      endfunction

      function void match_result(logic [2:0] kind, logic [7:0] ch, logic present,
                                 logic first, logic last, logic run_end);
         result_type want;
         if (expected.size() == 0) begin
            $error("result transaction with nothing expected: kind %0d char %h", kind, ch);
            errors++;
            return;
         end
         want = expected.pop_front();
         if (kind !== want.token_kind) begin
            $error("token_kind: expected %0d, actual %0d", want.token_kind, kind);
            errors++;
         end
         if (ch !== want.char_out) begin
            $error("char_out: expected %h, actual %h", want.char_out, ch);
            errors++;
         end
         if (present !== want.char_present) begin
            $error("char_present: expected %b, actual %b", want.char_present, present);
            errors++;
         end
         if (first !== want.token_first) begin
            $error("token_first: expected %b, actual %b", want.token_first, first);
            errors++;
         end
         if (last !== want.token_last) begin
            $error("token_last: expected %b, actual %b", want.token_last, last);
            errors++;
         end
         if (run_end !== want.run_last) begin
            $error("run_last: expected %b, actual %b", want.run_last, run_end);
            errors++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_text_byte = 8'h20;
   logic       req_end_of_text = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_token_kind;
   logic [7:0] rsp_char_out;
   logic       rsp_char_present;
   logic       rsp_token_first;
   logic       rsp_token_last;
   logic       rsp_run_last;

   lexer_scoreboard sb;
   int          bytes_sent = 0;
   int          burst_left = 0;
   int          gap_len;
   logic [7:0]  stmt_buf[$];
   int unsigned stall_style = 0;
   int unsigned stall_phase = 0;

   sql_text_tokenizer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_token_kind  (rsp_token_kind),
      .rsp_char_out    (rsp_char_out),
      .rsp_char_present(rsp_char_present),
      .rsp_token_first (rsp_token_first),
      .rsp_token_last  (rsp_token_last),
      .rsp_run_last    (rsp_run_last)
   );

   always #10 clock = ~clock;

   // receiver: switches between stall styles at random
   always @(negedge clock) begin
      if (stall_phase == 0) begin
         stall_style <= $urandom_range(0, 3);
         stall_phase <= $urandom_range(20, 80);
      end else begin
         stall_phase <= stall_phase - 1;
      end
      case (stall_style)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= stall_phase[1];
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.match_result(rsp_token_kind, rsp_char_out, rsp_char_present, rsp_token_first,
                         rsp_token_last, rsp_run_last);
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_byte(input logic [7:0] b, input logic eot);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap_len > 0) begin
            req_valid <= 1'b0;
            repeat (gap_len) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_text_byte <= b;
      req_end_of_text <= eot;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sb.take_byte(b, eot);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_str(input string s, input logic eot_last);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], eot_last && (i == s.len() - 1));
   endtask

   task automatic send_stmt_buf();
      for (int i = 0; i < stmt_buf.size(); i++)
         send_byte(stmt_buf[i], i == stmt_buf.size() - 1);
      stmt_buf.delete();
   endtask

   function automatic logic [7:0] rand_letter();
      case ($urandom_range(0, 2))
         0: return 8'("a" + $urandom_range(0, 25));
         1: return 8'("A" + $urandom_range(0, 25));
         default: return CH_UNDER;
      endcase
   endfunction

   function automatic logic [7:0] rand_digit();
      return 8'("0" + $urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] rand_blank();
      case ($urandom_range(0, 3))
         0: return CH_SPACE;
         1: return CH_TAB;
         2: return CH_CR;
         default: return CH_LF;
      endcase
   endfunction

   function automatic void add_token();
      int         len;
      logic [7:0] q;
      logic [7:0] c;
      string      punct;
      punct = "(),;*+-/%.";
      case ($urandom_range(0, 9))
         0, 1: begin
            stmt_buf.push_back(rand_letter());
            len = $urandom_range(0, 6);
            repeat (len)
               stmt_buf.push_back(($urandom_range(0, 3) == 0) ? rand_digit() : rand_letter());
         end
         2: begin
            stmt_buf.push_back(rand_digit());
            len = $urandom_range(0, 5);
            repeat (len)
               stmt_buf.push_back(($urandom_range(0, 3) == 0) ? CH_DOT : rand_digit());
         end
         3, 4: begin
            q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
            stmt_buf.push_back(q);
            len = $urandom_range(0, 5);
            repeat (len) begin
               case ($urandom_range(0, 7))
                  0, 1: c = 8'($urandom_range(1, 255));
                  2:    c = (q == CH_DQUOTE) ? CH_SQUOTE : CH_DQUOTE;
                  3:    c = rand_blank();
                  default: c = rand_letter();
               endcase
               stmt_buf.push_back((c == q) ? CH_SPACE : c);
            end
            // most strings close; open ones run into the next bytes or end of text
            if ($urandom_range(0, 6) != 0)
               stmt_buf.push_back(q);
         end
         5, 6: begin
            case ($urandom_range(0, 3))
               0: stmt_buf.push_back(CH_BANG);
               1: stmt_buf.push_back(CH_LT);
               2: stmt_buf.push_back(CH_GT);
               default: stmt_buf.push_back(CH_EQ);
            endcase
            if ($urandom_range(0, 4) != 0)
               stmt_buf.push_back($urandom_range(0, 3) ? CH_EQ : CH_GT);
         end
         7: begin
            if ($urandom_range(0, 1))
               stmt_buf.push_back(punct[$urandom_range(0, punct.len() - 1)]);
            else
               stmt_buf.push_back(8'($urandom_range(128, 255)));
         end
         8: stmt_buf.push_back(rand_blank());
         default: stmt_buf.push_back(8'($urandom_range(1, 255)));
      endcase
   endfunction

   initial begin
      int ntok;
      sb = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: all token kinds, every pair, both quotes, empty and open strings,
      // pair pending at end, byte extremes
      send_str("_a9 1.2\t<>=", 1'b1);
      send_str("''!=\"x'\">=", 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h01, 1'b0);
      send_str("<=\r==\n'q", 1'b1);
      send_str("\"", 1'b1);

      while (bytes_sent < 450) begin
         ntok = $urandom_range(1, 8);
         repeat (ntok) begin
            add_token();
            if ($urandom_range(0, 2) != 0)
               stmt_buf.push_back(rand_blank());
         end
         send_stmt_buf();
      end
      req_valid <= 1'b0;

      while (sb.expected.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.errors == 0)
         $display("[sql_text_tokenizer] OK");
      else
         $display("[sql_text_tokenizer] ERROR");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("[sql_text_tokenizer] ERROR");
      $finish;
   end

endmodule
`default_nettype wire

[sim.f]
src/stt_pkg.sv
src/stt_core.sv
src/stt_outq.sv
src/sql_text_tokenizer.sv
tb/tb_top.sv
